@@ hw/rtl/first_fit_region_allocator_core_defines.svh @@
// ----------------------------------------------------------------------------
// first fit region allocator assertion macros
// shared property shorthands for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_REGION_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define FFRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffra check failed");

// next-cycle implication, off during reset
`define FFRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffra check failed");

`endif

@@ hw/rtl/ffra_pkg.sv @@
// ----------------------------------------------------------------------------
// ffra_pkg
// shared types and constants of the first fit region allocator
// ----------------------------------------------------------------------------
`default_nettype none
package ffra_pkg;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 31;
  localparam int ENT_W  = ADDR_W + LEN_W;

  localparam logic [LEN_W-1:0] REGION_SIZE_RST = LEN_W'(4000000);

  localparam logic [0:0] CFG_REGION_BASE = 1'd0;
  localparam logic [0:0] CFG_REGION_SIZE = 1'd1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_TAIL,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/ffra_mem.sv @@
// ----------------------------------------------------------------------------
// ffra_mem
// segment table storage, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module ffra_mem
  import ffra_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [ENT_W-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [ENT_W-1:0] rd_data
);

  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/first_fit_region_allocator_core.sv @@
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// first fit allocator over one address region with an ordered segment table
// ----------------------------------------------------------------------------
// requests arrive on in_valid/in_stall: func 0 allocates req_size bytes,
// func 1 releases the block starting at free_address. each request gives
// exactly one result on out_valid/out_stall with a status and an address.
// the segment table sits in a memory with a registered read; each table
// entry visited is read, then evaluated or moved. zero size, full table and
// empty-table frees skip the table and go straight to the response state.
// one request is worked on at a time; in_stall is low only while idle.
// the result register lets the next request enter while a result waits;
// a stalled receiver holds the result and the block waits before writing
// the next one. region_base/region_size are written on cfg_we, which the
// user must raise only while idle; the block does not enforce it.
// synchronous reset empties the table (count only, no memory sweep) and
// restores region_base 0 and region_size 4000000.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_region_allocator_core
  import ffra_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_func,
  input  wire logic [LEN_W-1:0]  in_req_size,
  input  wire logic [ADDR_W-1:0] in_free_address,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [1:0]        out_status,
  output logic      [ADDR_W-1:0] out_address
);

  `include "first_fit_region_allocator_core_defines.svh"

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] base_r;
  logic [LEN_W-1:0]  size_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              func_r, func_nxt;
  logic [LEN_W-1:0]  req_r, req_nxt;
  logic [ADDR_W-1:0] faddr_r, faddr_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  logic [ADDR_W:0]   lo_r, lo_nxt;
  logic [ADDR_W-1:0] where_r, where_nxt;
  logic [1:0]        st_r, st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_address_r, out_address_nxt;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [ENT_W-1:0]  mem_wdata, mem_rdata;

  logic              accept;
  logic              out_free;
  logic [CW-1:0]     last_idx;
  logic              at_last;
  logic [ADDR_W-1:0] rd_start;
  logic [LEN_W-1:0]  rd_len;
  logic [ADDR_W:0]   rd_end;
  logic [ADDR_W:0]   base33, rend_raw, rend;
  logic [ADDR_W:0]   gap_hi, lo_c, hi_c, gap_len;
  logic              gap_fit;

  ffra_mem #(.DEPTH(MAX_SEGMENTS), .AW(IW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_address = out_address_r;

  assign last_idx = count_r - CW'(1);
  assign at_last  = (CW'(idx_r) == last_idx);
  assign rd_start = mem_rdata[ENT_W-1:LEN_W];
  assign rd_len   = mem_rdata[LEN_W-1:0];
  assign rd_end   = {1'b0, rd_start} + {2'b00, rd_len};

  // region end clipped to the top of the address space
  assign base33   = {1'b0, base_r};
  assign rend_raw = base33 + {2'b00, size_r};
  assign rend     = rend_raw[ADDR_W] ? {1'b1, {ADDR_W{1'b0}}} : rend_raw;

  // gap clipped to the region, strictly longer than the request
  assign gap_hi  = (state_r == S_TAIL) ? rend : {1'b0, rd_start};
  assign lo_c    = (lo_r < base33) ? base33 : lo_r;
  assign hi_c    = (gap_hi > rend) ? rend : gap_hi;
  assign gap_len = hi_c - lo_c;
  assign gap_fit = (hi_c > lo_c) && (gap_len > {2'b00, req_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_ALLOC) begin
            if (in_req_size == '0 || count_r == CNT_MAX) state_nxt = S_RESP;
            else if (count_r == '0)                      state_nxt = S_TAIL;
            else                                         state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = (count_r == '0) ? S_RESP : S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        if (func_r == FUNC_ALLOC) begin
          if (gap_fit)      state_nxt = S_SHIFT_RD;
          else if (at_last) state_nxt = S_TAIL;
          else              state_nxt = S_SCAN_RD;
        end else begin
          if (rd_start == faddr_r) state_nxt = at_last ? S_RESP : S_SHIFT_RD;
          else if (at_last)        state_nxt = S_RESP;
          else                     state_nxt = S_SCAN_RD;
        end
      end
      S_TAIL:     state_nxt = gap_fit ? S_PUT : S_RESP;
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (func_r == FUNC_ALLOC) state_nxt = (idx_r == pos_r) ? S_PUT : S_SHIFT_RD;
        else                      state_nxt = at_last ? S_RESP : S_SHIFT_RD;
      end
      S_PUT:  state_nxt = S_RESP;
      S_RESP: state_nxt = out_free ? S_IDLE : S_RESP;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt       = count_r;
    func_nxt        = func_r;
    req_nxt         = req_r;
    faddr_nxt       = faddr_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    lo_nxt          = lo_r;
    where_nxt       = where_r;
    st_nxt          = st_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_address_nxt = out_address_r;
    mem_we          = 1'b0;
    mem_waddr       = idx_r;
    mem_wdata       = mem_rdata;
    mem_raddr       = idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt  = in_func;
          req_nxt   = in_req_size;
          faddr_nxt = in_free_address;
          idx_nxt   = '0;
          lo_nxt    = {1'b0, base_r};
          where_nxt = '0;
          if (in_func == FUNC_ALLOC) begin
            st_nxt = (in_req_size == '0) ? ST_NOFIT :
                     (count_r == CNT_MAX) ? ST_FULL : ST_NOFIT;
          end else begin
            st_nxt = ST_NOTFOUND;
          end
        end
      end
      S_SCAN_EV: begin
        if (func_r == FUNC_ALLOC) begin
          if (gap_fit) begin
            pos_nxt   = idx_r;
            where_nxt = lo_c[ADDR_W-1:0];
            idx_nxt   = last_idx[IW-1:0];
          end else begin
            if (rd_end > lo_r) lo_nxt = rd_end;
            idx_nxt = idx_r + IW'(1);
          end
        end else if (rd_start == faddr_r) begin
          st_nxt  = ST_OK;
          idx_nxt = idx_r + IW'(1);
          if (at_last) count_nxt = count_r - CW'(1);
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_TAIL: begin
        if (gap_fit) begin
          pos_nxt   = count_r[IW-1:0];
          where_nxt = lo_c[ADDR_W-1:0];
        end
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
        if (func_r == FUNC_ALLOC) begin
          // move entry up one place to open a hole at pos
          mem_waddr = idx_r + IW'(1);
          idx_nxt   = idx_r - IW'(1);
        end else begin
          // close the hole left by the freed entry
          mem_waddr = idx_r - IW'(1);
          idx_nxt   = idx_r + IW'(1);
          if (at_last) count_nxt = count_r - CW'(1);
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = {where_r, req_r};
        count_nxt = count_r + CW'(1);
        st_nxt    = ST_OK;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = st_r;
          out_address_nxt = (func_r == FUNC_ALLOC && st_r == ST_OK) ? where_r : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      size_r      <= REGION_SIZE_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_REGION_BASE) base_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_REGION_SIZE) size_r <= cfg_wdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    req_r         <= req_nxt;
    faddr_r       <= faddr_nxt;
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    lo_r          <= lo_nxt;
    where_r       <= where_nxt;
    st_r          <= st_nxt;
    out_status_r  <= out_status_nxt;
    out_address_r <= out_address_nxt;
  end

  `FFRA_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_MAX)
  `FFRA_ASSERT_NOW(a_write_states, mem_we, state_r == S_SHIFT_WR || state_r == S_PUT)
  `FFRA_ASSERT_NEXT(a_put_grows, state_r == S_PUT, count_r == $past(count_r) + CW'(1))
  `FFRA_ASSERT_NEXT(a_idle_after_resp, state_r == S_RESP && out_free,
                    state_r == S_IDLE && out_valid_r)

endmodule
`default_nettype wire
